FILE: rtl/core/kft_pkg.sv
package kft_pkg;

	localparam int DATA_W = 64;
	localparam int COUNT_W = 32;
	localparam int POS_OUT_W = 9;
	localparam int GL_W = 6;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_BASES_DEF = 32;

	localparam logic [GL_W-1:0] GRAM_LENGTH_RESET = 6'd32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Register index, taken from paddr[2].
	localparam logic REG_GRAM_LENGTH = 1'b0;

	// Control flags of the request that walks along the chain.
	typedef struct packed {
		logic valid;
		logic found;
		logic is_new;
	} tok_flags_t;

endpackage

FILE: rtl/core/kmer_frequency_count_table.sv
// Counting table for DNA grams packed two bits per base, first base lowest.
// Requests enter on req_valid/req_stall with gram_bases; each gives one
// response on rsp_valid/rsp_stall with entry_position, entry_count, is_new
// and dropped_full. The gram_length register sits at byte address 0 of the
// APB port and is to be written by the user only while no request is in
// flight; the block itself does not enforce this. A request walks a chain
// of TABLE_DEPTH cells, one cell per cycle while the chain is not held;
// each cell holds one stored gram and its count. The next request is taken
// in the cycle after the previous one leaves the chain. Only one request is
// in the chain at a time; req_stall is high meanwhile. If a response still
// waits under rsp_stall when the next one reaches the end of the chain,
// the chain holds until the waiting response is taken. Reset empties the
// table and sets gram_length to 32; the stored grams need no clearing,
// since only entries below the fill count take part.
module kmer_frequency_count_table #(
	parameter int TABLE_DEPTH = kft_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_BASES = kft_pkg::MAX_BASES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kft_pkg::PADDR_W-1:0]   paddr,
	input  logic [kft_pkg::PDATA_W-1:0]   pwdata,
	output logic [kft_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [kft_pkg::DATA_W-1:0]    gram_bases,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [kft_pkg::POS_OUT_W-1:0] entry_position,
	output logic [kft_pkg::COUNT_W-1:0]   entry_count,
	output logic                          is_new,
	output logic                          dropped_full
);

	localparam int KEY_W = 2 * MAX_BASES;
	localparam int POS_W = $clog2(TABLE_DEPTH + 1);

	logic [KEY_W-1:0]            mask;
	logic                        busy_q;
	logic [POS_W-1:0]            used_q;
	logic                        out_valid_q;
	logic [kft_pkg::POS_OUT_W-1:0] out_pos_q;
	logic [kft_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_new_q;
	logic                        out_drop_q;

	kft_pkg::tok_flags_t         tok_flags [TABLE_DEPTH+1];
	logic [KEY_W-1:0]            tok_key   [TABLE_DEPTH+1];
	logic [kft_pkg::COUNT_W-1:0] tok_count [TABLE_DEPTH+1];
	logic [POS_W-1:0]            tok_pos   [TABLE_DEPTH+1];

	logic                        req_accept;
	logic                        adv;
	logic                        exit_take;
	kft_pkg::tok_flags_t         last;

	kft_regs #(
		.MAX_BASES(MAX_BASES),
		.KEY_W(KEY_W)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.mask(mask)
	);

	assign req_stall  = busy_q;
	assign req_accept = req_valid && !busy_q;
	assign last       = tok_flags[TABLE_DEPTH];
	assign adv        = !(last.valid && out_valid_q && rsp_stall);
	assign exit_take  = last.valid && adv;

	always_comb begin
		tok_flags[0].valid  = req_accept;
		tok_flags[0].found  = 1'b0;
		tok_flags[0].is_new = 1'b0;
	end
	assign tok_key[0]   = gram_bases[KEY_W-1:0] & mask;
	assign tok_count[0] = '0;
	assign tok_pos[0]   = '0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		kft_cell #(
			.IDX(g),
			.KEY_W(KEY_W),
			.POS_W(POS_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.mask(mask),
			.used(used_q),
			.prev_flags(tok_flags[g]),
			.prev_key(tok_key[g]),
			.prev_count(tok_count[g]),
			.prev_pos(tok_pos[g]),
			.next_flags(tok_flags[g+1]),
			.next_key(tok_key[g+1]),
			.next_count(tok_count[g+1]),
			.next_pos(tok_pos[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_accept) begin
				busy_q <= 1'b1;
			end else if (exit_take) begin
				busy_q <= 1'b0;
			end
			if (exit_take && last.is_new) begin
				used_q <= used_q + POS_W'(1);
			end
			if (exit_take) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exit_take) begin
			out_pos_q   <= last.found ? kft_pkg::POS_OUT_W'(tok_pos[TABLE_DEPTH]) : '0;
			out_count_q <= last.found ? tok_count[TABLE_DEPTH] : '0;
			out_new_q   <= last.is_new;
			out_drop_q  <= !last.found;
		end
	end

	assign rsp_valid      = out_valid_q;
	assign entry_position = out_pos_q;
	assign entry_count    = out_count_q;
	assign is_new         = out_new_q;
	assign dropped_full   = out_drop_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= POS_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !last.valid)
		else $error("request in chain while idle");

	a_new_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(exit_take && last.is_new) |=> (used_q == $past(used_q) + POS_W'(1)))
		else $error("new entry did not grow fill count");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(exit_take && !last.found) |-> (used_q == POS_W'(TABLE_DEPTH)))
		else $error("request dropped while table not full");
`endif

endmodule

FILE: rtl/core/kft_cell.sv
module kft_cell #(
	parameter int IDX = 0,
	parameter int KEY_W = 2 * kft_pkg::MAX_BASES_DEF,
	parameter int POS_W = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [KEY_W-1:0]              mask,
	input  logic [POS_W-1:0]              used,
	input  kft_pkg::tok_flags_t           prev_flags,
	input  logic [KEY_W-1:0]              prev_key,
	input  logic [kft_pkg::COUNT_W-1:0]   prev_count,
	input  logic [POS_W-1:0]              prev_pos,
	output kft_pkg::tok_flags_t           next_flags,
	output logic [KEY_W-1:0]              next_key,
	output logic [kft_pkg::COUNT_W-1:0]   next_count,
	output logic [POS_W-1:0]              next_pos
);

	logic [KEY_W-1:0]            key_q;
	logic [kft_pkg::COUNT_W-1:0] count_q;
	kft_pkg::tok_flags_t         flags_q;
	logic [KEY_W-1:0]            tok_key_q;
	logic [kft_pkg::COUNT_W-1:0] tok_count_q;
	logic [POS_W-1:0]            tok_pos_q;

	logic                        occupied;
	logic                        hit;
	logic                        append;
	logic [kft_pkg::COUNT_W-1:0] count_inc;

	assign occupied = POS_W'(IDX) < used;
	assign hit = prev_flags.valid && !prev_flags.found && occupied
		&& ((key_q & mask) == prev_key);
	assign append = prev_flags.valid && !prev_flags.found && (POS_W'(IDX) == used);
	assign count_inc = (count_q == kft_pkg::COUNT_MAX) ? count_q
		: count_q + kft_pkg::COUNT_W'(1);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (hit) begin
				count_q <= count_inc;
			end else if (append) begin
				key_q   <= prev_key;
				count_q <= kft_pkg::COUNT_W'(1);
			end
			tok_key_q <= prev_key;
			if (hit) begin
				tok_count_q <= count_inc;
				tok_pos_q   <= POS_W'(IDX + 1);
			end else if (append) begin
				tok_count_q <= kft_pkg::COUNT_W'(1);
				tok_pos_q   <= POS_W'(IDX + 1);
			end else begin
				tok_count_q <= prev_count;
				tok_pos_q   <= prev_pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (adv) begin
			flags_q.valid  <= prev_flags.valid;
			flags_q.found  <= prev_flags.found || hit || append;
			flags_q.is_new <= prev_flags.is_new || append;
		end
	end

	assign next_flags = flags_q;
	assign next_key   = tok_key_q;
	assign next_count = tok_count_q;
	assign next_pos   = tok_pos_q;

endmodule

FILE: rtl/core/kft_regs.sv
module kft_regs #(
	parameter int MAX_BASES = kft_pkg::MAX_BASES_DEF,
	parameter int KEY_W = 2 * MAX_BASES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kft_pkg::PADDR_W-1:0]   paddr,
	input  logic [kft_pkg::PDATA_W-1:0]   pwdata,
	output logic [kft_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [KEY_W-1:0]              mask
);

	logic [kft_pkg::GL_W-1:0] gram_length_q;
	logic [KEY_W-1:0]         mask_q;
	logic [kft_pkg::GL_W-1:0] len;
	logic [KEY_W-1:0]         mask_next;
	logic                     wr_gram_length;

	assign pready = 1'b1;
	assign wr_gram_length = psel && penable && pwrite
		&& (paddr[2] == kft_pkg::REG_GRAM_LENGTH);

	// Effective length is clamped to one base at least and MAX_BASES at most.
	always_comb begin
		len = pwdata[kft_pkg::GL_W-1:0];
		if (len == '0) begin
			len = kft_pkg::GL_W'(1);
		end
		if (len > kft_pkg::GL_W'(MAX_BASES)) begin
			len = kft_pkg::GL_W'(MAX_BASES);
		end
		for (int b = 0; b < KEY_W; b++) begin
			mask_next[b] = (b < 2 * int'(len));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gram_length_q <= kft_pkg::GRAM_LENGTH_RESET;
			mask_q        <= '1;
		end else if (wr_gram_length) begin
			gram_length_q <= pwdata[kft_pkg::GL_W-1:0];
			mask_q        <= mask_next;
		end
	end

	always_comb begin
		if (paddr[2] == kft_pkg::REG_GRAM_LENGTH) begin
			prdata = {{(kft_pkg::PDATA_W - kft_pkg::GL_W){1'b0}}, gram_length_q};
		end else begin
			prdata = '0;
		end
	end

	assign mask = mask_q;

endmodule
